@@ rtl/krl_pkg.sv @@
package krl_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SLOT_OUT_W = 6;
  localparam logic [5:0] KEY_MAX_LEN = 6'd33;

  typedef struct packed {
    logic [63:0] word0;
    logic [63:0] word1;
    logic [63:0] word2;
    logic [63:0] word3;
    logic [7:0]  byte32;
    logic [5:0]  len;
    logic [31:0] seen;
  } entry_t;

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
  } cmd_t;

  typedef struct packed {
    logic             cmp_vld;
    logic [IDX_W-1:0] cmp_idx;
    logic             hit;
    logic             ok;
    logic [IDX_W-1:0] min_idx;
  } sts_t;

  function automatic logic [63:0] word_mask(input logic [1:0] w, input logic [5:0] len);
    logic [63:0] m;
    logic [5:0]  idx;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      idx = {1'b0, w, 3'(b)};
      m[63-8*b -: 8] = (idx < len) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

@@ rtl/krl_datapath.sv @@
module krl_datapath
  import krl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        cfg_valid_i,
  input  logic [31:0] cfg_min_interval_i,
  input  logic [63:0] key_word0_i,
  input  logic [63:0] key_word1_i,
  input  logic [63:0] key_word2_i,
  input  logic [63:0] key_word3_i,
  input  logic [7:0]  key_byte32_i,
  input  logic [5:0]  key_length_i,
  input  logic [31:0] now_time_i
);

  entry_t           mem [TABLE_ENTRIES];
  entry_t           rd_data_q;
  entry_t           key_q;
  entry_t           key_d;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [31:0]      min_interval_q;
  logic [31:0]      min_q;
  logic [IDX_W-1:0] min_idx_q;
  logic [5:0]       len_sat;
  logic             hit;
  logic [31:0]      age;

  assign len_sat = (key_length_i > KEY_MAX_LEN) ? KEY_MAX_LEN : key_length_i;

  always_comb begin
    key_d.word0  = key_word0_i & word_mask(2'd0, len_sat);
    key_d.word1  = key_word1_i & word_mask(2'd1, len_sat);
    key_d.word2  = key_word2_i & word_mask(2'd2, len_sat);
    key_d.word3  = key_word3_i & word_mask(2'd3, len_sat);
    key_d.byte32 = (len_sat == KEY_MAX_LEN) ? key_byte32_i : 8'd0;
    key_d.len    = len_sat;
    key_d.seen   = now_time_i;
  end

  assign hit = (rd_data_q.len == key_q.len) && (rd_data_q.word0 == key_q.word0) &&
               (rd_data_q.word1 == key_q.word1) && (rd_data_q.word2 == key_q.word2) &&
               (rd_data_q.word3 == key_q.word3) && (rd_data_q.byte32 == key_q.byte32);
  assign age = key_q.seen - rd_data_q.seen;

  always_comb begin
    sts_o.cmp_vld = rd_vld_q;
    sts_o.cmp_idx = rd_idx_q;
    sts_o.hit     = hit;
    sts_o.ok      = (age >= min_interval_q);
    sts_o.min_idx = min_idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= key_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[cmd_i.rd_addr];
    end
    if (cmd_i.load) begin
      key_q <= key_d;
    end
    if (rd_vld_q && ((rd_idx_q == '0) || (rd_data_q.seen < min_q))) begin
      min_q     <= rd_data_q.seen;
      min_idx_q <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q       <= 1'b0;
      rd_idx_q       <= '0;
      min_interval_q <= 32'd60;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      rd_idx_q <= cmd_i.rd_addr;
      if (cfg_valid_i) begin
        min_interval_q <= cfg_min_interval_i;
      end
    end
  end

endmodule

@@ rtl/krl_ctrl.sv @@
module krl_ctrl
  import krl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  admitted_o,
  output logic                  found_existing_o,
  output logic [SLOT_OUT_W-1:0] slot_index_o,
  output logic                  evicted_o,
  output cmd_t                  cmd_o,
  input  sts_t                  sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_WRITE,
    S_RESP
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] addr_q;
  logic             issue_done_q;
  logic [IDX_W-1:0] slot_q;
  logic             admitted_q;
  logic             found_q;
  logic             evicted_q;
  logic [CNT_W-1:0] last_idx;
  logic             full;

  assign last_idx = count_q - CNT_W'(1);
  assign full     = (count_q == CNT_W'(TABLE_ENTRIES));

  always_comb begin
    cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.rd_en   = (state_q == S_SCAN) && !issue_done_q;
    cmd_o.rd_addr = addr_q;
    cmd_o.wr_en   = (state_q == S_WRITE);
    cmd_o.wr_addr = slot_q;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = (state_q == S_RESP);
  assign admitted_o       = admitted_q;
  assign found_existing_o = found_q;
  assign slot_index_o     = SLOT_OUT_W'(slot_q);
  assign evicted_o        = evicted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      addr_q       <= '0;
      issue_done_q <= 1'b0;
      slot_q       <= '0;
      admitted_q   <= 1'b0;
      found_q      <= 1'b0;
      evicted_q    <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            addr_q       <= '0;
            issue_done_q <= 1'b0;
            state_q      <= (count_q == '0) ? S_PICK : S_SCAN;
          end
        end
        S_SCAN: begin
          if (cmd_o.rd_en) begin
            addr_q <= addr_q + IDX_W'(1);
            if (CNT_W'(addr_q) == last_idx) begin
              issue_done_q <= 1'b1;
            end
          end
          if (sts_i.cmp_vld) begin
            if (sts_i.hit) begin
              found_q    <= 1'b1;
              admitted_q <= sts_i.ok;
              evicted_q  <= 1'b0;
              slot_q     <= sts_i.cmp_idx;
              state_q    <= sts_i.ok ? S_WRITE : S_RESP;
            end else if (CNT_W'(sts_i.cmp_idx) == last_idx) begin
              state_q <= S_PICK;
            end
          end
        end
        S_PICK: begin
          found_q    <= 1'b0;
          admitted_q <= 1'b1;
          evicted_q  <= full;
          if (full) begin
            slot_q <= sts_i.min_idx;
          end else begin
            slot_q  <= count_q[IDX_W-1:0];
            count_q <= count_q + CNT_W'(1);
          end
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/keyed_rate_limit_table.sv @@
// Flow: an accepted key is compared with the stored entries in slot order; a new key
// then picks a free or the oldest slot and is written; an empty table skips the scan,
// and a match ends the scan, with a write only when admitted. One item at a time; the
// next item is taken only after the result is delivered.
// Reset: asynchronous, active low; clears the entry count and sets min_interval to
// 60. Table contents are not cleared and need no clearing pass.
module keyed_rate_limit_table
  import krl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [31:0]           cfg_min_interval_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [63:0]           key_word0_i,
  input  logic [63:0]           key_word1_i,
  input  logic [63:0]           key_word2_i,
  input  logic [63:0]           key_word3_i,
  input  logic [7:0]            key_byte32_i,
  input  logic [5:0]            key_length_i,
  input  logic [31:0]           now_time_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  admitted_o,
  output logic                  found_existing_o,
  output logic [SLOT_OUT_W-1:0] slot_index_o,
  output logic                  evicted_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  krl_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .admitted_o       (admitted_o),
    .found_existing_o (found_existing_o),
    .slot_index_o     (slot_index_o),
    .evicted_o        (evicted_o),
    .cmd_o            (cmd),
    .sts_i            (sts)
  );

  krl_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_min_interval_i (cfg_min_interval_i),
    .key_word0_i        (key_word0_i),
    .key_word1_i        (key_word1_i),
    .key_word2_i        (key_word2_i),
    .key_word3_i        (key_word3_i),
    .key_byte32_i       (key_byte32_i),
    .key_length_i       (key_length_i),
    .now_time_i         (now_time_i)
  );

endmodule

@@ dv/krl_admit_checker.sv @@
`timescale 1ns / 100ps
module krl_admit_checker
  import krl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [31:0]           cfg_min_interval_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [63:0]           key_word0_i,
  input  logic [63:0]           key_word1_i,
  input  logic [63:0]           key_word2_i,
  input  logic [63:0]           key_word3_i,
  input  logic [7:0]            key_byte32_i,
  input  logic [5:0]            key_length_i,
  input  logic [31:0]           now_time_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  admitted_i,
  input  logic                  found_existing_i,
  input  logic [SLOT_OUT_W-1:0] slot_index_i,
  input  logic                  evicted_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  localparam logic [31:0] GAP_AT_RESET = 32'd60;

  typedef struct packed {
    logic                  admitted;
    logic                  found;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evicted;
  } verdict_t;

  logic [31:0]  rate_gap = GAP_AT_RESET;
  int           fill_count = 0;
  logic [263:0] slot_key  [TABLE_ENTRIES];
  logic [5:0]   slot_len  [TABLE_ENTRIES];
  logic [31:0]  slot_seen [TABLE_ENTRIES];
  verdict_t     verdict_q [$];
  int unsigned  mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic verdict_t admit_request(input logic [263:0] raw, input logic [5:0] len_in,
                                             input logic [31:0] now);
    verdict_t     v;
    logic [5:0]   len;
    logic [263:0] key;
    logic [31:0]  age;
    int           slot;
    bit           hit;
    len = (len_in > KEY_MAX_LEN) ? KEY_MAX_LEN : len_in;
    // drop bytes past the length
    key = raw & ~({264{1'b1}} >> (8 * len));
    hit = 1'b0;
    slot = 0;
    for (int i = 0; i < fill_count; i++) begin
      if (!hit && slot_len[i] == len && slot_key[i] == key) begin
        hit = 1'b1;
        slot = i;
      end
    end
    v = '0;
    if (hit) begin
      age = now - slot_seen[slot];
      v.found = 1'b1;
      v.slot = SLOT_OUT_W'(slot);
      if (age >= rate_gap) begin
        v.admitted = 1'b1;
        slot_seen[slot] = now;
      end
      return v;
    end
    if (fill_count < TABLE_ENTRIES) begin
      slot = fill_count;
      fill_count++;
    end else begin
      slot = 0;
      for (int i = 1; i < TABLE_ENTRIES; i++) begin
        if (slot_seen[i] < slot_seen[slot]) slot = i;
      end
      v.evicted = 1'b1;
    end
    slot_key[slot] = key;
    slot_len[slot] = len;
    slot_seen[slot] = now;
    v.admitted = 1'b1;
    v.slot = SLOT_OUT_W'(slot);
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      rate_gap = GAP_AT_RESET;
      fill_count = 0;
      verdict_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) rate_gap = cfg_min_interval_i;
      if (in_valid_i && !in_stall_i) begin
        verdict_q.push_back(admit_request({key_word0_i, key_word1_i, key_word2_i, key_word3_i,
                                           key_byte32_i}, key_length_i, now_time_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result item with no request outstanding");
        end else begin
          want = verdict_q.pop_front();
          if (admitted_i !== want.admitted)
            report_mismatch($sformatf("admitted got %0b expected %0b", admitted_i,
                                      want.admitted));
          if (found_existing_i !== want.found)
            report_mismatch($sformatf("found_existing got %0b expected %0b",
                                      found_existing_i, want.found));
          if (slot_index_i !== want.slot)
            report_mismatch($sformatf("slot_index got %0d expected %0d", slot_index_i,
                                      want.slot));
          if (evicted_i !== want.evicted)
            report_mismatch($sformatf("evicted got %0b expected %0b", evicted_i,
                                      want.evicted));
        end
      end
    end
    pending_o <= verdict_q.size();
    fail_count_o <= mismatches;
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
  import krl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned SEGMENTS     = 6;
  localparam int unsigned POOL_MAX     = 100;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam logic [263:0] ALL_ONES    = {264{1'b1}};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [31:0]           cfg_gap = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [63:0]           key_w0 = '0;
  logic [63:0]           key_w1 = '0;
  logic [63:0]           key_w2 = '0;
  logic [63:0]           key_w3 = '0;
  logic [7:0]            key_b32 = '0;
  logic [5:0]            key_len = 6'd1;
  logic [31:0]           now_time = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  admitted;
  logic                  found_existing;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic                  evicted;
  int unsigned           failures;
  int unsigned           pending;

  int unsigned  snd_idle_pct = 0;
  int unsigned  rcv_idle_pct = 0;
  int unsigned  cycle_count = 0;
  logic [263:0] pool_key [POOL_MAX];
  logic [5:0]   pool_len [POOL_MAX];
  int unsigned  pool_size = 1;
  logic [31:0]  clock_now = '0;

  keyed_rate_limit_table dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_min_interval_i (cfg_gap),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .key_word0_i        (key_w0),
    .key_word1_i        (key_w1),
    .key_word2_i        (key_w2),
    .key_word3_i        (key_w3),
    .key_byte32_i       (key_b32),
    .key_length_i       (key_len),
    .now_time_i         (now_time),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .admitted_o         (admitted),
    .found_existing_o   (found_existing),
    .slot_index_o       (slot_index),
    .evicted_o          (evicted)
  );

  krl_admit_checker admit_chk (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_min_interval_i (cfg_gap),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .key_word0_i        (key_w0),
    .key_word1_i        (key_w1),
    .key_word2_i        (key_w2),
    .key_word3_i        (key_w3),
    .key_byte32_i       (key_b32),
    .key_length_i       (key_len),
    .now_time_i         (now_time),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .admitted_i         (admitted),
    .found_existing_i   (found_existing),
    .slot_index_i       (slot_index),
    .evicted_i          (evicted),
    .fail_count_o       (failures),
    .pending_o          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [263:0] rand_key();
    logic [263:0] k;
    k = '0;
    for (int i = 0; i < 9; i++) k = (k << 32) | 264'($urandom);
    return k;
  endfunction

  function automatic logic [5:0] rand_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 25) return KEY_MAX_LEN;
    if (roll < 35) return 6'd1;
    if (roll < 45) return 6'd32;
    return 6'($urandom_range(1, 33));
  endfunction

  task automatic send_item(input logic [263:0] raw, input logic [5:0] len,
                           input logic [31:0] now);
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid <= 1'b1;
    key_w0   <= raw[263:200];
    key_w1   <= raw[199:136];
    key_w2   <= raw[135:72];
    key_w3   <= raw[71:8];
    key_b32  <= raw[7:0];
    key_len  <= len;
    now_time <= now;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_gap(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_gap   <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic build_pool();
    int unsigned src;
    int unsigned pos;
    pool_size = $urandom_range(16, POOL_MAX);
    for (int i = 0; i < pool_size; i++) begin
      pool_key[i] = rand_key();
      pool_len[i] = rand_len();
      if (i > 0 && $urandom_range(2) != 0) begin
        src = $urandom_range(i - 1);
        pool_key[i] = pool_key[src];
        // same bytes with one bit flipped, or same prefix at another length
        if ($urandom_range(1) == 1) begin
          pool_len[i] = pool_len[src];
          pos = $urandom_range(pool_len[src] - 1);
          pool_key[i][263 - 8 * pos -: 8] = pool_key[i][263 - 8 * pos -: 8] ^
                                            8'(1 << $urandom_range(7));
        end
      end
    end
  endtask

  task automatic send_random();
    logic [263:0] raw;
    logic [263:0] keep;
    logic [5:0]   len;
    int unsigned  pick;
    int unsigned  roll;
    raw = rand_key();
    if ($urandom_range(99) < 85) begin
      pick = $urandom_range(pool_size - 1);
      len = pool_len[pick];
      keep = ~(ALL_ONES >> (8 * len));
      raw = (pool_key[pick] & keep) | (raw & ~keep);
    end else begin
      len = rand_len();
    end
    roll = $urandom_range(99);
    if (roll >= 92) clock_now = $urandom();
    else if (roll >= 70) clock_now += $urandom_range(41, 400);
    else if (roll >= 20) clock_now += $urandom_range(1, 40);
    send_item(raw, len, clock_now);
  endtask

  initial begin : stimulus
    logic [263:0] g;
    logic [31:0]  gap;
    g = rand_key();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(ALL_ONES, 6'd1, 32'd100);
    send_item({8'hFF, g[255:0]}, 6'd1, 32'd130);
    send_item({8'hFF, g[263:8]}, 6'd1, 32'd160);
    send_item(ALL_ONES, 6'd33, 32'd0);
    send_item({ALL_ONES[263:8], 8'h00}, 6'd33, 32'd0);
    send_item(ALL_ONES, 6'd32, 32'hFFFF_FFFF);
    send_item(ALL_ONES, 6'd33, 32'd59);
    send_item('0, 6'd8, 32'hFFFF_FFF0);
    send_item({64'h0, g[199:0]}, 6'd8, 32'h0000_002C);
    send_item('0, 6'd8, 32'h0000_002D);
    send_item('0, 6'd33, 32'd0);
    send_item('0, 6'd16, 32'hFFFF_FFFF);
    send_item({64'h0, 8'h80, 192'h0}, 6'd9, 32'd5);
    send_item({8'h01, g[255:0]}, 6'd2, 32'd7);
    send_item({8'h01, g[263:8]}, 6'd2, 32'd7);
    send_item(~g, 6'd33, 32'd1000);
    send_item(g, 6'd33, 32'd1000);
    send_item(g, 6'd17, 32'd1000);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      in_valid <= 1'b0;
      wait_for_drain();
      case (seg)
        0: gap = 32'd0;
        1: gap = 32'hFFFF_FFFF;
        2: gap = 32'd1000;
        3: gap = 32'd1;
        4: gap = 32'd60;
        default: gap = $urandom_range(0, 500);
      endcase
      write_gap(gap);
      if (seg < 2) begin
        snd_idle_pct = 17;
        rcv_idle_pct = 63;
      end else if (seg < 4) begin
        snd_idle_pct = 63;
        rcv_idle_pct = 17;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      build_pool();
      clock_now = ($urandom_range(1) == 1) ? 32'hFFFF_FE00 : $urandom();
      repeat (RANDOM_ITEMS / SEGMENTS) send_random();
    end

    in_valid <= 1'b0;
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
